// ===== hdl/frustum_sphere_cull_macros.svh =====
// Assertion macros shared by the frustum sphere cull RTL.
`ifndef FRUSTUM_SPHERE_CULL_MACROS_SVH
`define FRUSTUM_SPHERE_CULL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frustum sphere cull assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frustum sphere cull assertion failed");

`endif

// ===== hdl/fsc_pkg.sv =====
// Package with widths, stream layout and sequencer states of the frustum sphere cull.
`default_nettype none

package fsc_pkg;

    // Fixed-point format and internal widths.
    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 32;
    localparam int RAW_W     = VAL_W + 1;
    localparam int PROD_W    = 2 * RAW_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int ROOT_W    = RAW_W;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int NUM_W     = RAW_W + FRAC_BITS;
    localparam int RAD_W     = 31;

    // Input stream layout.
    localparam int IDX_LSB   = 0;
    localparam int VALUE_LSB = 4;
    localparam int CX_LSB    = 36;
    localparam int CY_LSB    = 68;
    localparam int CZ_LSB    = 100;
    localparam int RAD_LSB   = 132;
    localparam int S_DATA_W  = 168;
    localparam int M_DATA_W  = 8;

    // Operation codes carried in s_tuser.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Index of the last matrix element; writing it rebuilds the planes.
    localparam logic [3:0] LAST_ELEMENT = 4'd15;
    localparam logic [2:0] LAST_PLANE   = 3'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_A,
        ST_LD_B,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQ_CHK,
        ST_SQRT,
        ST_DIV_GO,
        ST_DIV,
        ST_STORE,
        ST_T_MUL,
        ST_T_ACC,
        ST_T_CHK,
        ST_RESULT
    } fsc_state_t;

endpackage

`default_nettype wire

// ===== hdl/fsc_mul.sv =====
// Shared signed multiplier with a registered product.
`default_nettype none

module fsc_mul (
    input  wire logic                               aclk,
    input  wire logic signed [fsc_pkg::RAW_W-1:0]   op_a,
    input  wire logic signed [fsc_pkg::RAW_W-1:0]   op_b,
    output logic signed [fsc_pkg::PROD_W-1:0]       prod
);
    import fsc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // One multiplication per cycle, product held for the accumulator.
    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hdl/fsc_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none

module fsc_isqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [fsc_pkg::SQ_W-1:0]      radicand,
    output logic                               done,
    output logic [fsc_pkg::ROOT_W-1:0]         root
);
    import fsc_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic [SQ_W-1:0]   rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_shift;
    logic [REM_W+1:0]  trial;
    logic              take;

    // Bring down two radicand bits and try the next root bit.
    always_comb begin
        rem_shift = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        take      = (rem_shift >= trial);
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[SQ_W-3:0], 2'b00};
            rem_reg  <= take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== hdl/fsc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module fsc_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [fsc_pkg::NUM_W-1:0]     dividend,
    input  wire logic [fsc_pkg::ROOT_W-1:0]    divisor,
    output logic                               done,
    output logic [fsc_pkg::NUM_W-1:0]          quotient
);
    import fsc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W:0]   rem_shift;
    logic              take;

    // Shift in the next dividend bit and compare with the divisor.
    always_comb begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        take      = (rem_shift >= {1'b0, den_reg});
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= take ? ROOT_W'(rem_shift - {1'b0, den_reg}) : ROOT_W'(rem_shift);
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/frustum_sphere_cull.sv =====
// Top level of the frustum sphere cull: sequencer, matrix and plane stores.
//
// Frustum sphere cull. A load transfer (s_tuser = 0) writes one view-projection
// matrix element; writing element 15 also rebuilds the six normalized planes,
// which keeps the block busy: per plane it fetches the matrix rows, forms the
// squared length through the shared multiplier, checks it for zero, takes the
// bit-serial square root and runs the bit-serial divider per component. A plane
// of zero length skips the root and the divider. A test transfer (s_tuser = 1)
// runs the single shared multiplier for three products per plane, stops at the
// first plane whose sum is negative and yields one result transfer with inside_res
// in m_tdata bit 0. The block accepts the next transfer while a result still
// waits on m_tready.
`default_nettype none

module frustum_sphere_cull (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // element_index, element_value, center_x, center_y, center_z, radius, zero pad
    input  wire logic [fsc_pkg::S_DATA_W-1:0]  s_tdata,
    // op
    input  wire logic [0:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // inside_res, zero pad
    output logic [fsc_pkg::M_DATA_W-1:0]       m_tdata
);
    import fsc_pkg::*;
    `include "frustum_sphere_cull_macros.svh"

    fsc_state_t state_reg, state_next;

    logic signed [VAL_W-1:0]  mat_reg [16];
    logic signed [VAL_W-1:0]  pln_reg [24];

    logic [2:0]               plane_reg;
    logic [1:0]               comp_reg;
    logic signed [VAL_W-1:0]  a_reg;
    logic signed [RAW_W-1:0]  raw_reg [4];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [VAL_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [RAD_W-1:0]         rad_reg;
    logic                     degen_reg;
    logic                     res_reg;
    logic                     out_valid_reg;
    logic                     out_bit_reg;

    // Sequencer outputs.
    logic                     s_accept;
    logic [3:0]               mat_addr;
    logic [4:0]               pln_addr;
    logic signed [RAW_W-1:0]  mul_a, mul_b;
    logic                     sqrt_start, div_start;
    logic                     out_load;

    // Unit results.
    logic signed [PROD_W-1:0] prod;
    logic                     sqrt_done, div_done;
    logic [ROOT_W-1:0]        root;
    logic [NUM_W-1:0]         quotient;

    // Datapath values.
    logic [3:0]               in_idx;
    logic signed [VAL_W-1:0]  mat_rd, pln_rd, ctr_sel;
    logic signed [RAW_W-1:0]  raw_new, raw_cur, w_rad;
    logic [RAW_W-1:0]         raw_mag;
    logic signed [ACC_W-1:0]  acc_sum, test_sum;
    logic signed [VAL_W-1:0]  store_val;
    logic                     q_big;

    assign in_idx   = s_tdata[IDX_LSB +: 4];
    assign s_accept = s_tvalid && s_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser[0] == OP_TEST) begin
                        state_next = ST_T_MUL;
                    end else if (in_idx == LAST_ELEMENT) begin
                        state_next = ST_LD_A;
                    end
                end
            end
            ST_LD_A:   state_next = ST_LD_B;
            ST_LD_B:   state_next = (comp_reg == 2'd3) ? ST_SQ_MUL : ST_LD_A;
            ST_SQ_MUL: state_next = ST_SQ_ACC;
            ST_SQ_ACC: state_next = (comp_reg == 2'd2) ? ST_SQ_CHK : ST_SQ_MUL;
            ST_SQ_CHK: state_next = (acc_reg == '0) ? ST_STORE : ST_SQRT;
            ST_SQRT:   state_next = sqrt_done ? ST_DIV_GO : ST_SQRT;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV:    state_next = div_done ? ST_STORE : ST_DIV;
            ST_STORE: begin
                if (comp_reg == 2'd3) begin
                    state_next = (plane_reg == LAST_PLANE) ? ST_IDLE : ST_LD_A;
                end else begin
                    state_next = degen_reg ? ST_STORE : ST_DIV_GO;
                end
            end
            ST_T_MUL:  state_next = ST_T_ACC;
            ST_T_ACC:  state_next = (comp_reg == 2'd2) ? ST_T_CHK : ST_T_MUL;
            ST_T_CHK: begin
                if (test_sum[ACC_W-1] || plane_reg == LAST_PLANE) begin
                    state_next = ST_RESULT;
                end else begin
                    state_next = ST_T_MUL;
                end
            end
            ST_RESULT: state_next = (!out_valid_reg || m_tready) ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: store addresses, multiplier operands and unit starts.
    always_comb begin
        s_tready   = (state_reg == ST_IDLE);
        mat_addr   = (state_reg == ST_LD_A) ? {comp_reg, 2'd3} : {comp_reg, plane_reg[2:1]};
        pln_addr   = {plane_reg, comp_reg};
        sqrt_start = (state_reg == ST_SQ_CHK) && (acc_reg != '0);
        div_start  = (state_reg == ST_DIV_GO);
        out_load   = (state_reg == ST_RESULT) && (!out_valid_reg || m_tready);
        unique case (comp_reg)
            2'd0:    ctr_sel = cx_reg;
            2'd1:    ctr_sel = cy_reg;
            default: ctr_sel = cz_reg;
        endcase
        if (state_reg == ST_T_MUL) begin
            mul_a = {pln_rd[VAL_W-1], pln_rd};
            mul_b = {ctr_sel[VAL_W-1], ctr_sel};
        end else begin
            mul_a = raw_cur;
            mul_b = raw_cur;
        end
    end

    // Store reads, plane arithmetic and result saturation.
    always_comb begin
        mat_rd   = mat_reg[mat_addr];
        pln_rd   = pln_reg[pln_addr[4:0]];
        raw_cur  = raw_reg[comp_reg];
        raw_new  = plane_reg[0] ? ({a_reg[VAL_W-1], a_reg} - {mat_rd[VAL_W-1], mat_rd})
                                : ({a_reg[VAL_W-1], a_reg} + {mat_rd[VAL_W-1], mat_rd});
        raw_mag  = raw_cur[RAW_W-1] ? RAW_W'(-raw_cur) : RAW_W'(raw_cur);
        acc_sum  = acc_reg + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
        w_rad    = {pln_rd[VAL_W-1], pln_rd} + {2'b00, rad_reg};
        test_sum = acc_reg + ({{(ACC_W-RAW_W){w_rad[RAW_W-1]}}, w_rad} <<< FRAC_BITS);
        q_big    = |quotient[NUM_W-1:VAL_W-1];
        if (degen_reg) begin
            if (!raw_cur[RAW_W-1] && raw_cur[VAL_W-1]) begin
                store_val = {1'b0, {(VAL_W-1){1'b1}}};
            end else if (raw_cur[RAW_W-1] && !raw_cur[VAL_W-1]) begin
                store_val = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                store_val = raw_cur[VAL_W-1:0];
            end
        end else if (raw_cur[RAW_W-1]) begin
            store_val = q_big ? {1'b1, {(VAL_W-1){1'b0}}} : -quotient[VAL_W-1:0];
        end else begin
            store_val = q_big ? {1'b0, {(VAL_W-1){1'b1}}} : quotient[VAL_W-1:0];
        end
    end

    // Shared arithmetic units.
    fsc_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    fsc_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg[SQ_W-1:0]),
        .done     (sqrt_done),
        .root     (root)
    );

    fsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({raw_mag, {FRAC_BITS{1'b0}}}),
        .divisor  (root),
        .done     (div_done),
        .quotient (quotient)
    );

    // Matrix and plane stores, cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= '0;
            end
            for (int i = 0; i < 24; i++) begin
                pln_reg[i] <= '0;
            end
        end else begin
            if (s_accept && s_tuser[0] == OP_LOAD) begin
                mat_reg[in_idx] <= s_tdata[VALUE_LSB +: VAL_W];
            end
            if (state_reg == ST_STORE) begin
                pln_reg[pln_addr] <= store_val;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            comp_reg      <= '0;
            degen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            priority case (state_reg)
                ST_IDLE: begin
                    plane_reg <= '0;
                    comp_reg  <= '0;
                end
                ST_LD_B:   comp_reg <= comp_reg + 1'b1;
                ST_SQ_ACC: comp_reg <= (comp_reg == 2'd2) ? 2'd0 : comp_reg + 1'b1;
                ST_SQ_CHK: degen_reg <= (acc_reg == '0);
                ST_STORE: begin
                    comp_reg <= comp_reg + 1'b1;
                    if (comp_reg == 2'd3) begin
                        plane_reg <= plane_reg + 1'b1;
                    end
                end
                ST_T_ACC:  comp_reg <= comp_reg + 1'b1;
                ST_T_CHK: begin
                    comp_reg  <= '0;
                    plane_reg <= plane_reg + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser[0] == OP_TEST) begin
            cx_reg  <= s_tdata[CX_LSB +: VAL_W];
            cy_reg  <= s_tdata[CY_LSB +: VAL_W];
            cz_reg  <= s_tdata[CZ_LSB +: VAL_W];
            rad_reg <= s_tdata[RAD_LSB +: RAD_W];
            acc_reg <= '0;
        end
        if (state_reg == ST_LD_A) begin
            a_reg <= mat_rd;
        end
        if (state_reg == ST_LD_B) begin
            raw_reg[comp_reg] <= raw_new;
            acc_reg           <= '0;
        end
        if (state_reg == ST_SQ_ACC || state_reg == ST_T_ACC) begin
            acc_reg <= acc_sum;
        end
        if (state_reg == ST_T_CHK) begin
            acc_reg <= '0;
            res_reg <= !test_sum[ACC_W-1];
        end
        if (out_load) begin
            out_bit_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W-1){1'b0}}, out_bit_reg};

    // Sequencer checks. The plane counter steps one past the last plane
    // when a pass runs through it and is cleared again in the idle state.
    `FSC_ASSERT_NXT(a_test_start, aclk, aresetn, s_accept && s_tuser[0] == OP_TEST,
        state_reg == ST_T_MUL && acc_reg == '0 && plane_reg == 3'd0)
    `FSC_ASSERT_NXT(a_rebuild_start, aclk, aresetn,
        s_accept && s_tuser[0] == OP_LOAD && in_idx == LAST_ELEMENT,
        state_reg == ST_LD_A && plane_reg == 3'd0 && comp_reg == 2'd0)
    `FSC_ASSERT_IMP(a_mul_comp, aclk, aresetn,
        state_reg == ST_SQ_MUL || state_reg == ST_T_MUL, comp_reg != 2'd3)
    `FSC_ASSERT_IMP(a_plane_range, aclk, aresetn, 1'b1,
        plane_reg != 3'd7)

endmodule

`default_nettype wire
